// File: design/brs_pkg.sv
package brs_pkg;

	// Table size default
	localparam int TABLE_DEPTH_DEF = 1024;

	// Field widths
	localparam int IDENT_W  = 10;
	localparam int SCORE_W  = 32;
	localparam int MARKER_W = 16;
	localparam int TOL_W    = 16;

	// Item modes
	localparam logic [1:0] MODE_RECORD = 2'd0;
	localparam logic [1:0] MODE_SELECT = 2'd1;
	localparam logic [1:0] MODE_CLEAR  = 2'd2;

	localparam logic [TOL_W-1:0] TOL_RESET = 16'd1024;

	// Shared divider geometry
	localparam int DVD_W  = 40;
	localparam int DVS_W  = 16;
	localparam int DCNT_W = 6;

	// Weight arithmetic widths
	localparam int KV_W   = 38;	// biased ratio in Q.32, always non-negative
	localparam int QK_W   = 6;	// biased exponent k + 24
	localparam int G_W    = 32;	// fractional remainder g, Q.32
	localparam int TERM_W = 33;
	localparam int SUM_W  = 34;
	localparam int W_W    = 49;	// weight, unsigned Q25.24
	localparam int STEP_W = 5;

	// ln 2 in Q.32 and 24 * ln 2 used to bias the ratio positive
	localparam logic [G_W-1:0]  LN2_Q32 = 32'd2977044472;
	localparam logic [KV_W:0]   LN2_X24 = 39'd71449067328;
	localparam logic [QK_W-1:0] K_BIAS  = 6'd32;	// shift = k - 8 = qk - 32

	// Ratio clamp limits, magnitude form
	localparam logic [DVD_W-1:0] RATIO_POS_MAX = 40'd1048575;
	localparam logic [DVD_W-1:0] RATIO_NEG_MAX = 40'd1048576;
	localparam logic [20:0]      RATIO_NEG_MIN = 21'h100000;

	// Step counter marks
	localparam logic [STEP_W-1:0] K_FIRST    = 5'd5;
	localparam logic [STEP_W-1:0] TERM_FIRST = 5'd1;
	localparam logic [STEP_W-1:0] TERM_LAST  = 5'd14;
	localparam logic [STEP_W-1:0] THR_LAST   = 5'd15;

	// Controller to datapath commands
	typedef struct packed {
		logic load_in;
		logic idx_clr;
		logic idx_inc;
		logic sel_init;
		logic rec_update;
		logic rec_append;
		logic fill_clr;
		logic div_ratio;
		logic ratio_take;
		logic k_step;
		logic mul;
		logic div_term;
		logic term_take;
		logic shift;
		logic acc_total;
		logic acc_run;
		logic sel_take;
		logic thr_init;
		logic thr_step;
		logic pass1_init;
		logic out_load;
	} brs_cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic [1:0] mode;
		logic       idx_end;
		logic       ident_hit;
		logic       div_done;
		logic       k_last;
		logic       term_last;
		logic       thr_last;
		logic       run_hit;
	} brs_sts_t;

endpackage

// File: design/brs_div.sv
module brs_div (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [brs_pkg::DVD_W-1:0]   dividend,
	input  logic [brs_pkg::DVS_W-1:0]   divisor,
	output logic [brs_pkg::DVD_W-1:0]   quotient,
	output logic                        done
);
	import brs_pkg::*;

	logic                busy_q;
	logic                done_q;
	logic [DCNT_W-1:0]   cnt_q;
	logic [DVS_W-1:0]    rem_q;
	logic [DVD_W-1:0]    quo_q;
	logic [DVS_W-1:0]    dvs_q;
	logic [DVS_W:0]      rem_sh;
	logic [DVS_W:0]      diff;
	logic                ge;

	// One restoring step: shift in next dividend bit, trial subtract
	always_comb begin
		rem_sh = {rem_q, quo_q[DVD_W-1]};
		diff   = rem_sh - {1'b0, dvs_q};
		ge     = rem_sh >= {1'b0, dvs_q};
	end

	// Control: one quotient bit per cycle, done pulses after the last
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= DCNT_W'(DVD_W - 1);
		end else if (busy_q) begin
			if (cnt_q == '0) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
			cnt_q <= cnt_q - 1'b1;
		end else begin
			done_q <= 1'b0;
		end
	end

	// Remainder and quotient shift registers
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dvs_q <= divisor;
		end else if (busy_q) begin
			rem_q <= ge ? diff[DVS_W-1:0] : rem_sh[DVS_W-1:0];
			quo_q <= {quo_q[DVD_W-2:0], ge};
		end
	end

	assign quotient = quo_q;
	assign done     = done_q;

endmodule

// File: design/brs_datapath.sv
module brs_datapath #(
	parameter int TABLE_DEPTH = brs_pkg::TABLE_DEPTH_DEF
) (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    cfg_write_en,
	input  logic [brs_pkg::TOL_W-1:0]               cfg_write_data,
	input  logic [1:0]                              mode,
	input  logic [brs_pkg::IDENT_W-1:0]             entry_index,
	input  logic signed [brs_pkg::SCORE_W-1:0]      score,
	input  logic [brs_pkg::MARKER_W-1:0]            marker,
	input  brs_pkg::brs_cmd_t                       cmd,
	output brs_pkg::brs_sts_t                       sts,
	output logic                                    accepted,
	output logic                                    table_full,
	output logic [brs_pkg::IDENT_W-1:0]             selected_index,
	output logic                                    selected_valid,
	output logic [$clog2(TABLE_DEPTH+1)-1:0]        entry_count
);
	import brs_pkg::*;

	localparam int ADDR_W = $clog2(TABLE_DEPTH);
	localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);
	localparam int TOT_W  = W_W + ADDR_W;
	localparam int THR_W  = TOT_W + MARKER_W;

	// Configuration and table occupancy
	logic [TOL_W-1:0]  tol_q;
	logic [CNT_W-1:0]  fill_q;
	logic [CNT_W-1:0]  idx_q;

	// Latched transaction
	logic [1:0]               mode_q;
	logic [IDENT_W-1:0]       ident_in_q;
	logic [SCORE_W-1:0]       score_in_q;
	logic [MARKER_W-1:0]      marker_q;

	// Table memories
	logic [IDENT_W-1:0] ident_mem [TABLE_DEPTH];
	logic [SCORE_W-1:0] score_mem [TABLE_DEPTH];
	logic [IDENT_W-1:0] rd_ident_q;
	logic [SCORE_W-1:0] rd_score_q;
	logic               ident_we;
	logic               score_we;
	logic [ADDR_W-1:0]  wr_addr;
	logic               table_is_full;
	logic               score_ok;

	// Weight unit
	logic               neg_q;
	logic [KV_W-1:0]    kv_q;
	logic [QK_W-1:0]    qk_q;
	logic [STEP_W-1:0]  step_q;
	logic [TERM_W-1:0]  term_q;
	logic [SUM_W-1:0]   sum_q;
	logic [TERM_W-1:0]  prod_q;
	logic [W_W-1:0]     weight_q;
	logic [TOT_W-1:0]   total_q;
	logic [TOT_W-1:0]   running_q;
	logic [THR_W-1:0]   thracc_q;

	// Results of the current transaction and the output register
	logic                res_acc_q;
	logic                res_full_q;
	logic [IDENT_W-1:0]  res_sel_q;
	logic                res_valid_q;
	logic                out_acc_q;
	logic                out_full_q;
	logic [IDENT_W-1:0]  out_sel_q;
	logic                out_valid_q;
	logic [CNT_W-1:0]    out_count_q;

	// Divider hookup
	logic                div_start;
	logic [DVD_W-1:0]    div_dvd;
	logic [DVS_W-1:0]    div_dvs;
	logic [DVD_W-1:0]    div_quo;
	logic                div_done;

	logic [SCORE_W-1:0]  score_mag;
	logic [20:0]         ratio;
	logic [KV_W:0]       kv_biased;
	logic [KV_W:0]       k_trial;
	logic [TERM_W+G_W-1:0] prod_full;
	logic [QK_W-1:0]     lsh;
	logic [QK_W-1:0]     rsh;
	logic [W_W-1:0]      weight_nx;
	logic [TOT_W:0]      run_sum;
	logic [TOT_W-1:0]    thr;

	// Configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tol_q <= TOL_RESET;
		end else if (cfg_write_en) begin
			tol_q <= cfg_write_data;
		end
	end

	// Latch the accepted transaction
	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			mode_q     <= mode;
			ident_in_q <= entry_index;
			score_in_q <= score;
			marker_q   <= marker;
		end
	end

	// Table memory: registered read at the scan index
	assign table_is_full = fill_q == CNT_W'(TABLE_DEPTH);
	assign score_ok      = $signed(rd_score_q) <= $signed(score_in_q);
	assign ident_we      = cmd.rec_append && !table_is_full;
	assign score_we      = ident_we || (cmd.rec_update && score_ok);
	assign wr_addr       = cmd.rec_append ? fill_q[ADDR_W-1:0] : idx_q[ADDR_W-1:0];

	always_ff @(posedge clk) begin
		if (ident_we) begin
			ident_mem[wr_addr] <= ident_in_q;
		end
		rd_ident_q <= ident_mem[idx_q[ADDR_W-1:0]];
	end

	always_ff @(posedge clk) begin
		if (score_we) begin
			score_mem[wr_addr] <= score_in_q;
		end
		rd_score_q <= score_mem[idx_q[ADDR_W-1:0]];
	end

	// Fill count and scan index
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
		end else if (cmd.fill_clr) begin
			fill_q <= '0;
		end else if (ident_we) begin
			fill_q <= fill_q + 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
		end else if (cmd.idx_clr || cmd.pass1_init) begin
			idx_q <= '0;
		end else if (cmd.idx_inc) begin
			idx_q <= idx_q + 1'b1;
		end
	end

	// Divider operand select: score ratio or Taylor term by step index
	assign score_mag = rd_score_q[SCORE_W-1] ? (~rd_score_q + 1'b1) : rd_score_q;
	assign div_start = cmd.div_ratio || cmd.div_term;
	assign div_dvd   = cmd.div_ratio ? {score_mag, 8'd0} : DVD_W'(prod_q);
	assign div_dvs   = cmd.div_ratio ? ((tol_q == '0) ? DVS_W'(1) : tol_q)
	                                 : DVS_W'(step_q);

	brs_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dvd),
		.divisor  (div_dvs),
		.quotient (div_quo),
		.done     (div_done)
	);

	// Clamp the ratio and bias it by 24 ln 2 so k can be found unsigned
	always_comb begin
		if (neg_q) begin
			ratio = (div_quo > RATIO_NEG_MAX) ? RATIO_NEG_MIN : (~div_quo[20:0] + 1'b1);
		end else begin
			ratio = (div_quo > RATIO_POS_MAX) ? RATIO_POS_MAX[20:0] : div_quo[20:0];
		end
		kv_biased = {{2{ratio[20]}}, ratio, 16'd0} + LN2_X24;
		k_trial   = {1'b0, kv_q} - ((KV_W+1)'(LN2_Q32) << step_q);
		prod_full = term_q * kv_q[G_W-1:0];
	end

	// Final scaling of e^g by 2^(k-8)
	always_comb begin
		lsh = qk_q - K_BIAS;
		rsh = K_BIAS - qk_q;
		if (qk_q >= K_BIAS) begin
			weight_nx = W_W'(sum_q) << lsh;
		end else begin
			weight_nx = W_W'(sum_q >> rsh);
		end
	end

	assign thr     = thracc_q[THR_W-1:MARKER_W];
	assign run_sum = {1'b0, running_q} + (TOT_W+1)'(weight_q);

	// Weight unit registers
	always_ff @(posedge clk) begin
		if (cmd.div_ratio) begin
			neg_q <= rd_score_q[SCORE_W-1];
		end
		if (cmd.ratio_take) begin
			kv_q   <= kv_biased[KV_W-1:0];
			qk_q   <= '0;
			step_q <= K_FIRST;
		end else if (cmd.k_step) begin
			if (!k_trial[KV_W]) begin
				kv_q <= k_trial[KV_W-1:0];
			end
			qk_q <= {qk_q[QK_W-2:0], !k_trial[KV_W]};
			if (step_q == '0) begin
				// exponent found, start the series at 1.0
				step_q <= TERM_FIRST;
				term_q <= TERM_W'(64'h1_0000_0000);
				sum_q  <= SUM_W'(64'h1_0000_0000);
			end else begin
				step_q <= step_q - 1'b1;
			end
		end else if (cmd.term_take) begin
			term_q <= div_quo[TERM_W-1:0];
			sum_q  <= sum_q + SUM_W'(div_quo[TERM_W-1:0]);
			step_q <= step_q + 1'b1;
		end else if (cmd.thr_init) begin
			step_q   <= '0;
			thracc_q <= '0;
		end else if (cmd.thr_step) begin
			if (marker_q[step_q[3:0]]) begin
				thracc_q <= thracc_q + (THR_W'(total_q) << step_q[3:0]);
			end
			step_q <= step_q + 1'b1;
		end
		if (cmd.mul) begin
			prod_q <= prod_full[TERM_W+G_W-1:G_W];
		end
		if (cmd.shift) begin
			weight_q <= weight_nx;
		end
		if (cmd.sel_init) begin
			total_q <= '0;
		end else if (cmd.acc_total) begin
			total_q <= total_q + TOT_W'(weight_q);
		end
		if (cmd.pass1_init) begin
			running_q <= '0;
		end else if (cmd.acc_run) begin
			running_q <= run_sum[TOT_W-1:0];
		end
	end

	// Result of the current transaction
	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			res_acc_q   <= 1'b0;
			res_full_q  <= 1'b0;
			res_sel_q   <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (score_we) begin
				res_acc_q <= 1'b1;
			end
			if (cmd.rec_append && table_is_full) begin
				res_full_q <= 1'b1;
			end
			if (cmd.sel_take) begin
				res_sel_q   <= rd_ident_q;
				res_valid_q <= 1'b1;
			end
		end
	end

	// Output register
	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_acc_q   <= res_acc_q;
			out_full_q  <= res_full_q;
			out_sel_q   <= res_sel_q;
			out_valid_q <= res_valid_q;
			out_count_q <= fill_q;
		end
	end

	assign accepted       = out_acc_q;
	assign table_full     = out_full_q;
	assign selected_index = out_sel_q;
	assign selected_valid = out_valid_q;
	assign entry_count    = out_count_q;

	// Status to controller
	always_comb begin
		sts.mode      = mode_q;
		sts.idx_end   = idx_q == fill_q;
		sts.ident_hit = rd_ident_q == ident_in_q;
		sts.div_done  = div_done;
		sts.k_last    = step_q == '0;
		sts.term_last = step_q == TERM_LAST;
		sts.thr_last  = step_q == THR_LAST;
		sts.run_hit   = run_sum >= {1'b0, thr};
	end

endmodule

// File: design/brs_ctrl.sv
module brs_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	output logic                out_valid,
	input  logic                out_ready,
	input  brs_pkg::brs_sts_t   sts,
	output brs_pkg::brs_cmd_t   cmd
);
	import brs_pkg::*;

	localparam logic [3:0] S_IDLE      = 4'd0;
	localparam logic [3:0] S_DISP      = 4'd1;
	localparam logic [3:0] S_REC_RD    = 4'd2;
	localparam logic [3:0] S_REC_CMP   = 4'd3;
	localparam logic [3:0] S_REC_APP   = 4'd4;
	localparam logic [3:0] S_SEL_RD    = 4'd5;
	localparam logic [3:0] S_SEL_RDW   = 4'd6;
	localparam logic [3:0] S_SEL_DIVR  = 4'd7;
	localparam logic [3:0] S_SEL_K     = 4'd8;
	localparam logic [3:0] S_SEL_MUL   = 4'd9;
	localparam logic [3:0] S_SEL_DIVS  = 4'd10;
	localparam logic [3:0] S_SEL_DIVT  = 4'd11;
	localparam logic [3:0] S_SEL_SHIFT = 4'd12;
	localparam logic [3:0] S_SEL_ACC   = 4'd13;
	localparam logic [3:0] S_THR       = 4'd14;
	localparam logic [3:0] S_FIN       = 4'd15;

	logic [3:0] state_q;
	logic [3:0] state_nx;
	logic       pass_q;
	logic       pass_nx;
	logic       out_valid_q;

	assign in_ready  = state_q == S_IDLE;
	assign out_valid = out_valid_q;

	// Next state and commands
	always_comb begin
		cmd      = '0;
		state_nx = state_q;
		pass_nx  = pass_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load_in = 1'b1;
					state_nx    = S_DISP;
				end
			end
			S_DISP: begin
				unique case (sts.mode)
					MODE_RECORD: begin
						cmd.idx_clr = 1'b1;
						state_nx    = S_REC_RD;
					end
					MODE_SELECT: begin
						cmd.idx_clr  = 1'b1;
						cmd.sel_init = 1'b1;
						pass_nx      = 1'b0;
						state_nx     = S_SEL_RD;
					end
					MODE_CLEAR: begin
						cmd.fill_clr = 1'b1;
						state_nx     = S_FIN;
					end
					default: state_nx = S_FIN;
				endcase
			end
			// Record: linear search, then append if absent
			S_REC_RD: state_nx = sts.idx_end ? S_REC_APP : S_REC_CMP;
			S_REC_CMP: begin
				if (sts.ident_hit) begin
					cmd.rec_update = 1'b1;
					state_nx       = S_FIN;
				end else begin
					cmd.idx_inc = 1'b1;
					state_nx    = S_REC_RD;
				end
			end
			S_REC_APP: begin
				cmd.rec_append = 1'b1;
				state_nx       = S_FIN;
			end
			// Select: total pass, threshold, then search pass
			S_SEL_RD: begin
				if (sts.idx_end) begin
					if (!pass_q) begin
						cmd.thr_init = 1'b1;
						state_nx     = S_THR;
					end else begin
						state_nx = S_FIN;
					end
				end else begin
					state_nx = S_SEL_RDW;
				end
			end
			S_SEL_RDW: begin
				cmd.div_ratio = 1'b1;
				state_nx      = S_SEL_DIVR;
			end
			S_SEL_DIVR: begin
				if (sts.div_done) begin
					cmd.ratio_take = 1'b1;
					state_nx       = S_SEL_K;
				end
			end
			S_SEL_K: begin
				cmd.k_step = 1'b1;
				if (sts.k_last) begin
					state_nx = S_SEL_MUL;
				end
			end
			S_SEL_MUL: begin
				cmd.mul  = 1'b1;
				state_nx = S_SEL_DIVS;
			end
			S_SEL_DIVS: begin
				cmd.div_term = 1'b1;
				state_nx     = S_SEL_DIVT;
			end
			S_SEL_DIVT: begin
				if (sts.div_done) begin
					cmd.term_take = 1'b1;
					state_nx      = sts.term_last ? S_SEL_SHIFT : S_SEL_MUL;
				end
			end
			S_SEL_SHIFT: begin
				cmd.shift = 1'b1;
				state_nx  = S_SEL_ACC;
			end
			S_SEL_ACC: begin
				if (!pass_q) begin
					cmd.acc_total = 1'b1;
					cmd.idx_inc   = 1'b1;
					state_nx      = S_SEL_RD;
				end else if (sts.run_hit) begin
					cmd.sel_take = 1'b1;
					state_nx     = S_FIN;
				end else begin
					cmd.acc_run = 1'b1;
					cmd.idx_inc = 1'b1;
					state_nx    = S_SEL_RD;
				end
			end
			S_THR: begin
				cmd.thr_step = 1'b1;
				if (sts.thr_last) begin
					cmd.pass1_init = 1'b1;
					pass_nx        = 1'b1;
					state_nx       = S_SEL_RD;
				end
			end
			S_FIN: begin
				if (!out_valid_q || out_ready) begin
					cmd.out_load = 1'b1;
					state_nx     = S_IDLE;
				end
			end
			default: state_nx = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			pass_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			pass_q  <= pass_nx;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

// File: design/boltzmann_roulette_selector.sv
// Record searches the table linearly, then on a hit keeps the higher score, else appends;
// clear empties the table and no-op changes nothing. Select runs each entry through a
// ratio divide, an exponent search and 14 series terms, over a full first pass and a
// second pass up to the winner. Throughput: one transaction at a time; next input
// taken the cycle after the result moves into the output register.
// Reset: tolerance 1024, table empty; table memories are not cleared.
module boltzmann_roulette_selector #(
	parameter int TABLE_DEPTH = brs_pkg::TABLE_DEPTH_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_write_en,
	input  logic [brs_pkg::TOL_W-1:0]            cfg_write_data,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic [1:0]                           mode,
	input  logic [brs_pkg::IDENT_W-1:0]          entry_index,
	input  logic signed [brs_pkg::SCORE_W-1:0]   score,
	input  logic [brs_pkg::MARKER_W-1:0]         marker,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic                                 accepted,
	output logic                                 table_full,
	output logic [brs_pkg::IDENT_W-1:0]          selected_index,
	output logic                                 selected_valid,
	output logic [$clog2(TABLE_DEPTH+1)-1:0]     entry_count
);
	import brs_pkg::*;

	localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

	brs_cmd_t cmd;
	brs_sts_t sts;

	brs_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	brs_datapath #(
		.TABLE_DEPTH (TABLE_DEPTH)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_write_en   (cfg_write_en),
		.cfg_write_data (cfg_write_data),
		.mode           (mode),
		.entry_index    (entry_index),
		.score          (score),
		.marker         (marker),
		.cmd            (cmd),
		.sts            (sts),
		.accepted       (accepted),
		.table_full     (table_full),
		.selected_index (selected_index),
		.selected_valid (selected_valid),
		.entry_count    (entry_count)
	);

`ifndef ASSERT_OFF
	// Block is busy right after taking a transaction
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("input taken again right after a transaction");

	// Result flags of different modes never mix
	a_flags_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (!(accepted && table_full) &&
		!(selected_valid && (accepted || table_full))))
		else $error("result flags of different modes set together");

	// Entry count bounded by table depth
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (entry_count <= CNT_W'(TABLE_DEPTH)))
		else $error("entry count beyond table depth");

	// Divider never completes on the cycle after a ratio start
	a_div_latency: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_ratio |=> !sts.div_done)
		else $error("divider finished too early");
`endif

endmodule

// File: sim/testbench.sv
module testbench;
	timeunit 1ns;
	timeprecision 1ps;
	import brs_pkg::*;

	// Mode three carries no operation
	localparam logic [1:0] MODE_NOP = 2'd3;

	// Fitness table model and result store
	class fitness_board;
		localparam longint LN2_FIX = 64'd2977044472;
		logic [TOL_W-1:0]          tolerance;
		logic [IDENT_W-1:0]        idents[1024];
		logic signed [SCORE_W-1:0] scores[1024];
		int                        fill;
		logic [23:0]               due[$];	// accepted, full, index, valid, count
		int                        mismatches;

		function new();
			tolerance = TOL_RESET;
			fill = 0;
			mismatches = 0;
		endfunction

		// Boltzmann weight exp(score/tolerance), unsigned Q25.24
		function longint unsigned weight(logic signed [SCORE_W-1:0] sc);
			longint s, tol, r, rq, k, g;
			longint unsigned term, sum;
			s = sc;
			tol = (tolerance == 0) ? 1 : tolerance;
			r = (s * 256) / tol;
			if (r < -1048576) r = -1048576;
			if (r > 1048575) r = 1048575;
			rq = r * 65536;
			k = rq / LN2_FIX;
			if ((rq % LN2_FIX) != 0 && rq < 0) k--;
			g = rq - k * LN2_FIX;
			term = 64'd1 << 32;
			sum = term;
			for (int i = 1; i <= 14; i++) begin
				term = ((term * longint'(g)) >> 32) / longint'(i);
				sum += term;
			end
			if (k >= 8) return sum << (k - 8);
			return sum >> (8 - k);
		endfunction

		function void note_item(logic [1:0] md, logic [IDENT_W-1:0] id,
				logic signed [SCORE_W-1:0] sc, logic [MARKER_W-1:0] mk);
			logic acc, full, hit, vld;
			logic [IDENT_W-1:0] sel;
			longint unsigned total, running, thr;
			logic [23:0] res;
			acc = 0; full = 0; hit = 0; vld = 0; sel = '0;
			total = 0; running = 0;
			case (md)
				MODE_RECORD: begin
					for (int i = 0; i < fill; i++) begin
						if (!hit && idents[i] == id) begin
							hit = 1;
							if (scores[i] <= sc) begin
								scores[i] = sc;
								acc = 1;
							end
						end
					end
					if (!hit) begin
						if (fill < 1024) begin
							idents[fill] = id;
							scores[fill] = sc;
							fill++;
							acc = 1;
						end else begin
							full = 1;
						end
					end
				end
				MODE_SELECT: begin
					for (int i = 0; i < fill; i++) total += weight(scores[i]);
					thr = (total >> 16) * mk + (((total & 64'hFFFF) * mk) >> 16);
					for (int i = 0; i < fill; i++) begin
						running += weight(scores[i]);
						if (!vld && running >= thr) begin
							sel = idents[i];
							vld = 1;
						end
					end
				end
				MODE_CLEAR: fill = 0;
				default: ;
			endcase
			res = {acc, full, sel, vld, 11'(fill)};
			due.insert(due.size(), res);
		endfunction

		function void check_result(logic [23:0] got);
			logic [23:0] want;
			if (due.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected result %h", got);
				return;
			end
			want = due.pop_front();
			if (got !== want) begin
				mismatches++;
				if (mismatches <= 10)
					$display({"result mismatch: acc %b/%b full %b/%b idx %0d/%0d",
						" vld %b/%b cnt %0d/%0d"},
						want[23], got[23], want[22], got[22], want[21:12], got[21:12],
						want[11], got[11], want[10:0], got[10:0]);
			end
		endfunction
	endclass

	logic clk, arst_n;
	logic cfg_write_en;
	logic [TOL_W-1:0] cfg_write_data;
	logic in_valid, in_ready, out_valid, out_ready;
	logic [1:0] mode;
	logic [IDENT_W-1:0] entry_index;
	logic signed [SCORE_W-1:0] score;
	logic [MARKER_W-1:0] marker;
	logic accepted, table_full, selected_valid;
	logic [IDENT_W-1:0] selected_index;
	logic [10:0] entry_count;

	fitness_board board = new();
	int send_idle_pct, recv_idle_pct;

	boltzmann_roulette_selector i_dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_write_en(cfg_write_en), .cfg_write_data(cfg_write_data),
		.in_valid(in_valid), .in_ready(in_ready),
		.mode(mode), .entry_index(entry_index), .score(score), .marker(marker),
		.out_valid(out_valid), .out_ready(out_ready),
		.accepted(accepted), .table_full(table_full),
		.selected_index(selected_index), .selected_valid(selected_valid),
		.entry_count(entry_count)
	);

	initial begin
		clk = 0;
		forever #6 clk = ~clk;
	end

	// Monitors: input transactions feed the model, output transactions are checked
	always @(posedge clk) begin
		if (arst_n && in_valid && in_ready) board.note_item(mode, entry_index, score, marker);
		if (arst_n && out_valid && out_ready)
			board.check_result({accepted, table_full, selected_index, selected_valid,
				entry_count});
	end

	// Receiver stalls
	always @(posedge clk) begin
		out_ready <= arst_n && ($urandom_range(0, 99) >= recv_idle_pct);
	end

	task automatic send(logic [1:0] md, logic [IDENT_W-1:0] id,
			logic signed [SCORE_W-1:0] sc, logic [MARKER_W-1:0] mk);
		int gap;
		gap = 0;
		while ($urandom_range(0, 99) < send_idle_pct) gap++;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		mode <= md;
		entry_index <= id;
		score <= sc;
		marker <= mk;
		do @(posedge clk); while (!(in_valid && in_ready));
	endtask

	// Register write once the pipe has drained
	task automatic set_tolerance(logic [TOL_W-1:0] val);
		in_valid <= 1'b0;
		@(posedge clk);
		while (board.due.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
		cfg_write_en <= 1'b1;
		cfg_write_data <= val;
		@(posedge clk);
		board.tolerance = val;
		cfg_write_en <= 1'b0;
	endtask

	task automatic send_random();
		int pick;
		logic [1:0] md;
		logic [IDENT_W-1:0] id;
		logic signed [SCORE_W-1:0] sc;
		pick = $urandom_range(0, 99);
		if (pick < 50) md = MODE_RECORD;
		else if (pick < 88) md = MODE_SELECT;
		else if (pick < 96) md = MODE_CLEAR;
		else md = MODE_NOP;
		// keep the table short so selections stay quick
		if (board.fill >= 8 && md == MODE_RECORD) md = MODE_CLEAR;
		id = $urandom_range(0, 1) ? IDENT_W'($urandom_range(0, 7)) : IDENT_W'($urandom);
		sc = $urandom_range(0, 1) ? $urandom : $signed($urandom_range(0, 1 << 20)) - (1 << 19);
		send(md, id, sc, MARKER_W'($urandom_range(0, 65535)));
	endtask

	initial begin
		arst_n = 0;
		cfg_write_en = 0;
		cfg_write_data = '0;
		in_valid = 0;
		mode = MODE_RECORD;
		entry_index = '0;
		score = '0;
		marker = '0;
		send_idle_pct = 9;
		recv_idle_pct = 50;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: append, reject lower, equal overwrite, extremes, empty select
		send(MODE_SELECT, 10'd0, 32'sd0, 16'h8000);
		send(MODE_RECORD, 10'd0, 32'sd0, 16'd0);
		send(MODE_RECORD, 10'd1023, 32'sh7FFFFFFF, 16'hFFFF);
		send(MODE_RECORD, 10'd0, -32'sd1, 16'd0);
		send(MODE_RECORD, 10'd0, 32'sd0, 16'd0);
		send(MODE_RECORD, 10'd512, 32'sh80000000, 16'd0);
		send(MODE_RECORD, 10'h2AA, 32'sh00010000, 16'd0);
		send(MODE_SELECT, 10'h155, 32'sh55555555, 16'd0);
		send(MODE_SELECT, 10'd0, 32'sd0, 16'hFFFF);
		send(MODE_SELECT, 10'd0, 32'sd0, 16'h8000);
		send(MODE_NOP, 10'h3FF, -32'sd1, 16'hFFFF);
		send(MODE_CLEAR, 10'd0, 32'sd0, 16'd0);
		send(MODE_SELECT, 10'd0, 32'sd0, 16'h1234);
		send(MODE_RECORD, 10'd7, 32'sh00020000, 16'd0);
		send(MODE_RECORD, 10'd9, -32'sh00020000, 16'd0);
		set_tolerance(16'd1);
		send(MODE_SELECT, 10'd0, 32'sd0, 16'h4000);
		send(MODE_RECORD, 10'd3, 32'sh7FFFFFFF, 16'd0);
		send(MODE_SELECT, 10'd0, 32'sd0, 16'hC000);
		set_tolerance(16'hFFFF);
		send(MODE_SELECT, 10'd0, 32'sd0, 16'h7FFF);
		set_tolerance(16'd0);
		send(MODE_SELECT, 10'd0, 32'sd0, 16'h0001);
		send(MODE_CLEAR, 10'd0, 32'sd0, 16'd0);

		// Random phases with changing idle pattern and temperature
		set_tolerance(TOL_W'($urandom_range(1, 4096)));
		repeat (82) send_random();
		set_tolerance(TOL_W'($urandom_range(1, 65535)));
		send_idle_pct = 50;
		recv_idle_pct = 9;
		repeat (82) send_random();
		set_tolerance(TOL_RESET);
		send_idle_pct = 0;
		recv_idle_pct = 0;
		repeat (82) send_random();
		in_valid <= 1'b0;

		while (board.due.size() != 0) @(posedge clk);
		repeat (50) @(posedge clk);
		if (board.mismatches == 0) begin
			$display("testbench OK");
		end else begin
			$display("testbench NOT OK");
		end
		$finish;
	end

	// Run limit
	initial begin
		#200ms;
		$display("testbench NOT OK");
		$finish;
	end
endmodule
